FILE: hw/rtl/brb_pkg.sv
// Shared constants and types for the byte ring buffer.
package brb_pkg;

   // Storage depth in bytes; must be a power of two so index arithmetic wraps for free.
   localparam int CAPACITY = 4096;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = ADDR_W + 1;

   // Longest peek that is answered byte by byte.
   localparam int MAX_PEEK = 64;
   localparam int PEEK_W   = $clog2(MAX_PEEK + 1);

   localparam int FUNC_W   = 3;
   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 16;
   localparam int STATUS_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FN_WRITE  = 3'd0,
      FN_COMMIT = 3'd1,
      FN_POP    = 3'd2,
      FN_PEEK   = 3'd3,
      FN_WORD   = 3'd4
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_TOO_LONG  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RD0,
      S_RD1,
      S_EMIT,
      S_HOLD
   } state_type;

endpackage

FILE: hw/rtl/byte_ring_buffer.sv
// Byte ring buffer: circular byte store with read index, write index and fill count.
//
// The block serves one request at a time. A request is taken while req_stall is low, then a
// small sequencer walks it through decode, index update, storage reads and result output,
// using one wrapping index adder and one registered read port on the byte store for every
// step. A byte write, a commit, a pop, any failed request and any unused function code pass
// through the execute, result and hold states before the next request can be taken. A word
// read also passes through the read states S_RD0 and S_RD1, because both bytes come through
// the single read port with its registered data. A peek walks each byte through an address
// state, a data state and an output state. Every result carries the fill level and
// the contiguous writable and readable run lengths after the request; failed requests leave
// the indexes and the fill count as they were and report a nonzero status. The byte store
// has no reset: reading a location that was never written returns an undefined byte.
module byte_ring_buffer
   import brb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [CNT_W-1:0]    req_count,
   input  logic [ADDR_W-1:0]   req_offset,
   input  logic [BYTE_W-1:0]   req_data_in,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BYTE_W-1:0]   rsp_data_out,
   output logic [WORD_W-1:0]   rsp_word_out,
   output logic [CNT_W-1:0]    rsp_fill_level,
   output logic [CNT_W-1:0]    rsp_writable_run,
   output logic [CNT_W-1:0]    rsp_readable_run,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last
);

   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] PEEK_CNT = CNT_W'(MAX_PEEK);

   // Sequencer state and the captured request.
   state_type            state_ff, state_in;
   func_type             func_ff, func_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ADDR_W-1:0]    offset_ff, offset_in;
   logic [BYTE_W-1:0]    data_ff, data_in;

   // Ring state.
   logic [ADDR_W-1:0]    rd_ff, rd_in;
   logic [ADDR_W-1:0]    wr_ff, wr_in;
   logic [CNT_W-1:0]     stored_ff, stored_in;

   // Per-request working registers.
   status_type           status_ff, status_in;
   logic [PEEK_W-1:0]    idx_ff, idx_in;
   logic [BYTE_W-1:0]    lo_ff, lo_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [WORD_W-1:0]    rsp_word_ff, rsp_word_in;
   logic [CNT_W-1:0]     rsp_fill_ff, rsp_fill_in;
   logic [CNT_W-1:0]     rsp_wrun_ff, rsp_wrun_in;
   logic [CNT_W-1:0]     rsp_rrun_ff, rsp_rrun_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   // The shared index adder. Every storage address and every index update goes through it;
   // the power-of-two depth makes the truncated sum the wrapped index.
   logic [ADDR_W-1:0]    add_base;
   logic [ADDR_W-1:0]    add_step;
   logic [ADDR_W-1:0]    add_sum;

   // Byte store with one write and one registered read per cycle, both at add_sum.
   logic [BYTE_W-1:0]    mem [CAPACITY];
   logic [BYTE_W-1:0]    mem_q_ff;
   logic                 mem_we;

   logic [CNT_W-1:0]     free_bytes;
   logic                 straight;
   logic [CNT_W-1:0]     writable_run;
   logic [CNT_W-1:0]     readable_run;
   logic                 req_accept;
   logic                 rsp_accept;

   assign add_sum    = add_base + add_step;
   assign free_bytes = CAP_CNT - stored_ff;

   // With an empty store, or with the stored bytes not crossing the end of the array, the
   // free run reaches the end of the array and the stored run is the whole fill.
   assign straight     = (stored_ff == '0) || (rd_ff < wr_ff);
   assign writable_run = straight ? (CAP_CNT - CNT_W'(wr_ff))
                                  : (CNT_W'(rd_ff) - CNT_W'(wr_ff));
   assign readable_run = straight ? stored_ff : (CAP_CNT - CNT_W'(rd_ff));

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[add_sum] <= data_ff;
      end
      mem_q_ff <= mem[add_sum];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff        <= '0;
         wr_ff        <= '0;
         stored_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         stored_ff    <= stored_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      count_ff      <= count_in;
      offset_ff     <= offset_in;
      data_ff       <= data_in;
      status_ff     <= status_in;
      idx_ff        <= idx_in;
      lo_ff         <= lo_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_wrun_ff   <= rsp_wrun_in;
      rsp_rrun_ff   <= rsp_rrun_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Sequencer: next state, adder operand selection and all register updates.
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      count_in      = count_ff;
      offset_in     = offset_ff;
      data_in       = data_ff;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      stored_in     = stored_ff;
      status_in     = status_ff;
      idx_in        = idx_ff;
      lo_in         = lo_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_wrun_in   = rsp_wrun_ff;
      rsp_rrun_in   = rsp_rrun_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      add_base      = rd_ff;
      add_step      = '0;
      mem_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               func_in   = func_type'(req_func);
               count_in  = req_count;
               offset_in = req_offset;
               data_in   = req_data_in;
               state_in  = S_EXEC;
            end
         end

         // Check the request against the fill count and the peek limit, and store the byte or apply the index update.
         S_EXEC: begin
            idx_in    = '0;
            status_in = ST_OK;
            state_in  = S_EMIT;
            case (func_ff)
               FN_WRITE: begin
                  add_base = wr_ff;
                  add_step = offset_ff;
                  if (CNT_W'(offset_ff) >= free_bytes) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     mem_we = 1'b1;
                  end
               end
               FN_COMMIT: begin
                  add_base = wr_ff;
                  add_step = count_ff[ADDR_W-1:0];
                  if (count_ff > free_bytes) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     stored_in = stored_ff + count_ff;
                     wr_in     = add_sum;
                  end
               end
               FN_POP: begin
                  add_base = rd_ff;
                  add_step = count_ff[ADDR_W-1:0];
                  if (count_ff > stored_ff) begin
                     status_in = ST_UNDERFLOW;
                  end else begin
                     stored_in = stored_ff - count_ff;
                     rd_in     = add_sum;
                  end
               end
               FN_PEEK: begin
                  if (count_ff > stored_ff) begin
                     status_in = ST_UNDERFLOW;
                  end else if (count_ff > PEEK_CNT) begin
                     status_in = ST_TOO_LONG;
                  end else if (count_ff != '0) begin
                     state_in = S_RD0;
                  end
               end
               FN_WORD: begin
                  if (stored_ff < CNT_W'(2)) begin
                     status_in = ST_UNDERFLOW;
                  end else begin
                     state_in = S_RD0;
                  end
               end
               default: begin
               end
            endcase
         end

         // Address of the current peek byte, or of the low byte of a word.
         S_RD0: begin
            add_base = rd_ff;
            add_step = ADDR_W'(idx_ff);
            state_in = (func_ff == FN_WORD) ? S_RD1 : S_EMIT;
         end

         // Low byte arrives; address the high byte.
         S_RD1: begin
            add_base = rd_ff;
            add_step = ADDR_W'(1);
            lo_in    = mem_q_ff;
            state_in = S_EMIT;
         end

         S_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_fill_in   = stored_ff;
            rsp_wrun_in   = writable_run;
            rsp_rrun_in   = readable_run;
            rsp_status_in = status_ff;
            rsp_data_in   = '0;
            rsp_word_in   = '0;
            rsp_last_in   = 1'b1;
            if (func_ff == FN_PEEK && status_ff == ST_OK && count_ff != '0) begin
               rsp_data_in = mem_q_ff;
               rsp_last_in = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
            end
            if (func_ff == FN_WORD && status_ff == ST_OK) begin
               rsp_word_in = {mem_q_ff, lo_ff};
            end
            state_in = S_HOLD;
         end

         S_HOLD: begin
            if (rsp_accept) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + PEEK_W'(1);
                  state_in = S_RD0;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_out     = rsp_data_ff;
   assign rsp_word_out     = rsp_word_ff;
   assign rsp_fill_level   = rsp_fill_ff;
   assign rsp_writable_run = rsp_wrun_ff;
   assign rsp_readable_run = rsp_rrun_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

   // The fill count never exceeds the depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= CAP_CNT)
      else $error("fill count above capacity");

   // The write index always sits the fill count past the read index.
   a_index_gap: assert property (@(posedge clock) disable iff (reset)
      wr_ff == ADDR_W'(rd_ff + stored_ff[ADDR_W-1:0]))
      else $error("indexes disagree with fill count");

   // A result is only presented from the output hold state.
   a_valid_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_HOLD)
      else $error("result valid outside hold state");

   // A failed request gives exactly one result.
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> rsp_last_ff)
      else $error("failed request not marked last");

   // Taking the last result frees the block for the next request.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_last_ff) |=> state_ff == S_IDLE)
      else $error("block not idle after last result");

endmodule
